[hw/rtl/btd_pkg.sv]
// Shared types and constants for the block transposition decipher.
// Used by btd_ctrl, btd_datapath and block_transposition_decrypt; no dependencies.
`timescale 1ns / 1ps

package btd_pkg;

  // Default block buffer depth. The top level overrides it through its parameter.
  localparam int unsigned MAX_BLOCK_DEF = 16;

  // Fixed widths of the configuration registers and the data bytes.
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned KEY_ENTRY_W = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_TABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

  // Reset values. The key resets to the identity permutation.
  localparam logic [KEY_W-1:0] KEY_TABLE_RESET    = 64'hFEDC_BA98_7654_3210;
  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = 5'd16;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } btd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;
    logic clear_fill;
    logic out_load;
    logic pos_inc;
    logic pos_clear;
  } btd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic block_full;
    logic last_pos;
    logic out_free;
  } btd_status_t;

endpackage

[hw/rtl/btd_ctrl.sv]
// Controller state machine for the block transposition decipher.
// Depends on btd_pkg; drives the command struct of btd_datapath.
`timescale 1ns / 1ps

module btd_ctrl import btd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cipher_valid,
  output logic        cipher_stall,
  input  btd_status_t status,
  output btd_cmd_t    cmd
);

  btd_state_t state;
  btd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (cipher_valid && status.block_full) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.last_pos) begin
          state_next = ST_COLLECT;
        end
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cipher_stall = 1'b1;
    unique case (state)
      ST_COLLECT: begin
        cipher_stall  = 1'b0;
        cmd.load_byte = cipher_valid;
        cmd.clear_fill = cipher_valid && status.block_full;
      end
      ST_EMIT: begin
        cmd.out_load  = status.out_free;
        cmd.pos_inc   = status.out_free && !status.last_pos;
        cmd.pos_clear = status.out_free && status.last_pos;
      end
    endcase
  end

endmodule

[hw/rtl/btd_datapath.sv]
// Datapath of the block transposition decipher: block buffer, fill and position
// counters, inverse key search and the output word register. Depends on btd_pkg.
`timescale 1ns / 1ps

module btd_datapath import btd_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1),
  localparam int unsigned IDX_W = $clog2(MAX_BLOCK)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] cipher_byte,
  input  logic [KEY_W-1:0]  key_table,
  input  logic [CNT_W-1:0]  eff_len,
  input  btd_cmd_t          cmd,
  output btd_status_t       status,
  output logic [BYTE_W-1:0] plain_byte,
  output logic              block_end,
  output logic              plain_valid,
  input  logic              plain_stall
);

  logic [BYTE_W-1:0] block_store [MAX_BLOCK];
  logic [CNT_W-1:0]  fill_count;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  src;

  // The fill count never reaches MAX_BLOCK before a write, so its low bits index.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      block_store[fill_count[IDX_W-1:0]] <= cipher_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.clear_fill) begin
      fill_count <= '0;
    end else if (cmd.load_byte) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.pos_clear) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + IDX_W'(1);
    end
  end

  // Lowest block position whose key entry names the current output position;
  // position 0 when no entry in the active block matches.
  always_comb begin
    src = '0;
    for (int p = MAX_BLOCK - 1; p >= 0; p--) begin
      if ((CNT_W'(p) < eff_len) &&
          (key_table[KEY_ENTRY_W*p +: KEY_ENTRY_W] == KEY_ENTRY_W'(pos))) begin
        src = IDX_W'(p);
      end
    end
  end

  always_comb begin
    status.block_full = (fill_count + CNT_W'(1)) >= eff_len;
    status.last_pos   = (CNT_W'(pos) + CNT_W'(1)) == eff_len;
    status.out_free   = !plain_valid || !plain_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plain_valid <= 1'b0;
    end else if (cmd.out_load) begin
      plain_valid <= 1'b1;
    end else if (!plain_stall) begin
      plain_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      plain_byte <= block_store[src];
      block_end  <= status.last_pos;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_count < CNT_W'(MAX_BLOCK))
    else $error("fill count reached the buffer depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!plain_valid || !plain_stall))
    else $error("output word overwritten before it was taken");

  a_fill_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte && status.block_full) |=> (fill_count == '0))
    else $error("fill count not cleared after a full block");

  a_end_marks_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && status.last_pos) |=> (plain_valid && block_end))
    else $error("last word of a block not marked");

  a_phases_apart: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |-> !cmd.out_load)
    else $error("block gathered and emitted in the same cycle");
`endif

endmodule

[hw/rtl/block_transposition_decrypt.sv]
// Top level of the block transposition decipher: configuration registers,
// effective block length, and the btd_ctrl / btd_datapath pair. Depends on btd_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Signals                          Accepted when
//  cipher    in         cipher_byte                      cipher_valid && !cipher_stall
//  plain     out        plain_byte, block_end            plain_valid && !plain_stall
//  config    in         cfg_index, cfg_data              cfg_write
//
// A block of L bytes is gathered in L accepted input words, one per cycle. The
// block is then read out of the single block buffer one word per cycle through the
// output register, pausing while the output is stalled; the input is stalled until
// the last word of the block has been loaded into the output register.
// Reset is synchronous and active high; it clears the fill count, the output
// valid, the position counter and the state machine and restores the key and the block length.
// While the output is stalled the current word holds and readout pauses.

module block_transposition_decrypt import btd_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BYTE_W-1:0]      cipher_byte,
  input  logic                   cipher_valid,
  output logic                   cipher_stall,
  output logic [BYTE_W-1:0]      plain_byte,
  output logic                   block_end,
  output logic                   plain_valid,
  input  logic                   plain_stall,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);

  logic [KEY_W-1:0] key_table;
  logic [LEN_W-1:0] block_length;
  logic [CNT_W-1:0] eff_len;
  btd_cmd_t         cmd;
  btd_status_t      status;

  // Configuration registers. Writes to indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_table    <= KEY_TABLE_RESET;
      block_length <= BLOCK_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_TABLE:    key_table    <= cfg_data[KEY_W-1:0];
        REG_BLOCK_LENGTH: block_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one byte; lengths beyond the buffer act as a full buffer.
  always_comb begin
    priority if (block_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (block_length > LEN_W'(MAX_BLOCK)) begin
      eff_len = CNT_W'(MAX_BLOCK);
    end else begin
      eff_len = CNT_W'(block_length);
    end
  end

  // The controller alternates between gathering a block and reading it out.
  btd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the block buffer, the inverse key search and the output word.
  btd_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cipher_byte (cipher_byte),
    .key_table   (key_table),
    .eff_len     (eff_len),
    .cmd         (cmd),
    .status      (status),
    .plain_byte  (plain_byte),
    .block_end   (block_end),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall)
  );

endmodule
